FILE: src/pdscc_pkg.sv
package pdscc_pkg;

  // Widths of the data object and of the status code.
  localparam int PDO_W    = 32;
  localparam int STATUS_W = 4;
  localparam int VOLT_W   = 10;

  // Voltages are compared in 50 mV field units, so 5 V is field value 100.
  localparam int FIVE_VOLT_MV  = 5000;
  localparam int VOLT_UNIT_MV  = 50;
  localparam logic [VOLT_W-1:0] FIVE_VOLT_UNITS = VOLT_W'(FIVE_VOLT_MV / VOLT_UNIT_MV);

  // Role flags of a fixed object: dual role, unconstrained, comm capable, data swap.
  localparam logic [PDO_W-1:0] FIXED_FLAG_MASK = 32'h2E00_0000;

  // Object type held in bits 31:30.
  typedef enum logic [1:0] {
    TYPE_FIXED     = 2'd0,
    TYPE_BATTERY   = 2'd1,
    TYPE_VARIABLE  = 2'd2,
    TYPE_AUGMENTED = 2'd3
  } pdo_type_t;

  // Check result codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 4'd0,
    ST_FIRST_NOT_5V  = 4'd1,
    ST_FIXED_REPEAT  = 4'd2,
    ST_FIXED_ORDER   = 4'd3,
    ST_FIXED_FLAGS   = 4'd4,
    ST_BATT_REPEAT   = 4'd5,
    ST_BATT_ORDER    = 4'd6,
    ST_VAR_REPEAT    = 4'd7,
    ST_VAR_ORDER     = 4'd8,
    ST_AFTER_END     = 4'd9
  } status_t;

  // Which group of the list is expected next.
  typedef enum logic [4:0] {
    PH_FIRST = 5'b00001,
    PH_FIXED = 5'b00010,
    PH_BATT  = 5'b00100,
    PH_VAR   = 5'b01000,
    PH_TAIL  = 5'b10000
  } phase_t;

  // Checker state carried from one beat to the next.
  typedef struct packed {
    phase_t              phase;
    logic                prev_valid;
    logic [VOLT_W-1:0]   prev_min;
    logic [VOLT_W-1:0]   prev_max;
    status_t             err;
  } chk_state_t;

  localparam chk_state_t STATE_RESET = '{
    phase:      PH_FIRST,
    prev_valid: 1'b0,
    prev_min:   '0,
    prev_max:   '0,
    err:        ST_OK
  };

  // Ordering check shared by the battery and the variable groups.
  function automatic status_t range_status(
    input logic [VOLT_W-1:0] lo,
    input logic [VOLT_W-1:0] hi,
    input logic [VOLT_W-1:0] pmin,
    input logic [VOLT_W-1:0] pmax,
    input logic              pvalid,
    input status_t           rep_code,
    input status_t           ord_code
  );
    status_t res;
    res = ST_OK;
    if (pvalid) begin
      if (lo == pmin && hi == pmax) begin
        res = rep_code;
      end else if (lo < pmin || (lo == pmin && hi < pmax)) begin
        res = ord_code;
      end
    end
    return res;
  endfunction

endpackage

FILE: src/pdscc_pdo_if.sv
interface pdscc_pdo_if import pdscc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PDO_W-1:0] pdo_word;

  modport source (output valid, output pdo_word, input ready);
  modport sink   (input valid, input pdo_word, output ready);
endinterface

FILE: src/pdscc_status_if.sv
interface pdscc_status_if import pdscc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] check_status;

  modport source (output valid, output check_status, input ready);
  modport sink   (input valid, input check_status, output ready);
endinterface

FILE: src/pd_source_capability_checker_unit.sv
// A result beat is loaded into the result register when the last word of a list leaves
// the input register.
// Throughput: one word per cycle; the input register, the word check and the result
// register form one pass, and the input stalls only while a result waits at the output.
// Reset (rst_n low, synchronous): the list position, group state and error are cleared,
// and both the input and result registers are emptied.
module pd_source_capability_checker_unit import pdscc_pkg::*; #(
  parameter int MAX_OBJECTS = 7
) (
  input  logic           clk,
  input  logic           rst_n,
  pdscc_pdo_if.sink      in_pdo,
  pdscc_status_if.source out_status
);

  localparam int IDX_W = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_OBJECTS - 1);

  logic             s1_valid_r;
  logic             s1_valid_nxt;
  logic [PDO_W-1:0] s1_word_r;
  logic [IDX_W-1:0] idx_r;
  logic [IDX_W-1:0] idx_nxt;
  chk_state_t       state_r;
  chk_state_t       state_nxt;
  chk_state_t       chk_nxt;
  status_t          word_status;
  logic             s1_last;
  logic             s1_go;
  logic             out_can_load;
  logic             in_take;

  // Word check against the state left by the previous words.
  pdscc_word_check u_check (
    .pdo_word (s1_word_r),
    .cur      (state_r),
    .nxt      (chk_nxt)
  );

  // The last word of a list needs room in the result register.
  assign s1_last      = (idx_r == LAST_IDX);
  assign s1_go        = s1_valid_r && (!s1_last || out_can_load);
  assign in_pdo.ready = !s1_valid_r || s1_go;
  assign in_take      = in_pdo.valid && in_pdo.ready;
  assign s1_valid_nxt = in_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_r);

  // Once an error is latched, later words only advance the position.
  assign word_status = (state_r.err != ST_OK) ? state_r.err : chk_nxt.err;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    if (s1_go) begin
      if (s1_last) begin
        state_nxt = STATE_RESET;
        idx_nxt   = '0;
      end else begin
        idx_nxt = idx_r + IDX_W'(1);
        if (state_r.err == ST_OK) begin
          state_nxt = chk_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      idx_r      <= '0;
      state_r    <= STATE_RESET;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      idx_r      <= idx_nxt;
      state_r    <= state_nxt;
    end
  end

  // Input payload register.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word_r <= in_pdo.pdo_word;
    end
  end

  // Result register holding one status beat per list.
  pdscc_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (s1_go && s1_last),
    .status     (word_status),
    .can_load   (out_can_load),
    .out_status (out_status)
  );

endmodule

FILE: src/pdscc_word_check.sv
module pdscc_word_check import pdscc_pkg::*; (
  input  logic [PDO_W-1:0] pdo_word,
  input  chk_state_t       cur,
  output chk_state_t       nxt
);

  pdo_type_t         typ;
  logic [VOLT_W-1:0] lo;
  logic [VOLT_W-1:0] hi;
  logic              is_zero;
  status_t           rng;

  assign typ     = pdo_type_t'(pdo_word[31:30]);
  assign lo      = pdo_word[19:10];
  assign hi      = pdo_word[29:20];
  assign is_zero = (pdo_word == '0);

  // The previous range is only meaningful inside the group that set it.
  always_comb begin
    if (cur.phase == PH_VAR) begin
      rng = range_status(lo, hi, cur.prev_min, cur.prev_max, cur.prev_valid,
                         ST_VAR_REPEAT, ST_VAR_ORDER);
    end else begin
      rng = range_status(lo, hi, cur.prev_min, cur.prev_max, cur.prev_valid,
                         ST_BATT_REPEAT, ST_BATT_ORDER);
    end
  end

  // Next state and status for one word. A group change clears the previous voltages or
  // replaces them with the new word's own, so the first word of a new group can never be out of order.
  always_comb begin
    nxt     = cur;
    nxt.err = ST_OK;
    unique case (cur.phase)
      PH_FIRST: begin
        if (typ != TYPE_FIXED || lo != FIVE_VOLT_UNITS) begin
          nxt.err = ST_FIRST_NOT_5V;
        end else begin
          nxt.phase      = PH_FIXED;
          nxt.prev_valid = 1'b0;
        end
      end
      PH_FIXED: begin
        if (is_zero) begin
          nxt.phase = PH_TAIL;
        end else if (typ == TYPE_FIXED) begin
          if ((cur.prev_valid && lo == cur.prev_min) || lo == FIVE_VOLT_UNITS) begin
            nxt.err = ST_FIXED_REPEAT;
          end else if (cur.prev_valid && lo < cur.prev_min) begin
            nxt.err = ST_FIXED_ORDER;
          end else if ((pdo_word & FIXED_FLAG_MASK) != '0) begin
            nxt.err = ST_FIXED_FLAGS;
          end else begin
            nxt.prev_min   = lo;
            nxt.prev_valid = 1'b1;
          end
        end else if (typ == TYPE_BATTERY || typ == TYPE_VARIABLE) begin
          nxt.phase      = (typ == TYPE_BATTERY) ? PH_BATT : PH_VAR;
          nxt.prev_min   = lo;
          nxt.prev_max   = hi;
          nxt.prev_valid = 1'b1;
        end else begin
          nxt.phase = PH_TAIL;
          nxt.err   = ST_AFTER_END;
        end
      end
      PH_BATT: begin
        if (is_zero) begin
          nxt.phase = PH_TAIL;
        end else if (typ == TYPE_BATTERY) begin
          nxt.err = rng;
          if (rng == ST_OK) begin
            nxt.prev_min   = lo;
            nxt.prev_max   = hi;
            nxt.prev_valid = 1'b1;
          end
        end else if (typ == TYPE_VARIABLE) begin
          nxt.phase      = PH_VAR;
          nxt.prev_min   = lo;
          nxt.prev_max   = hi;
          nxt.prev_valid = 1'b1;
        end else begin
          nxt.phase = PH_TAIL;
          nxt.err   = ST_AFTER_END;
        end
      end
      PH_VAR: begin
        if (is_zero) begin
          nxt.phase = PH_TAIL;
        end else if (typ == TYPE_VARIABLE) begin
          nxt.err = rng;
          if (rng == ST_OK) begin
            nxt.prev_min   = lo;
            nxt.prev_max   = hi;
            nxt.prev_valid = 1'b1;
          end
        end else begin
          nxt.phase = PH_TAIL;
          nxt.err   = ST_AFTER_END;
        end
      end
      PH_TAIL: begin
        nxt.err = is_zero ? ST_OK : ST_AFTER_END;
      end
      default: begin
        nxt.phase = PH_FIRST;
      end
    endcase
  end

endmodule

FILE: src/pdscc_out_reg.sv
module pdscc_out_reg import pdscc_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  status_t        status,
  output logic           can_load,
  pdscc_status_if.source out_status
);

  logic    valid_r;
  logic    valid_nxt;
  status_t status_r;

  // The register may take a new beat when empty or when its beat leaves now.
  assign can_load  = !valid_r || out_status.ready;
  assign valid_nxt = load ? 1'b1 : (out_status.ready ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load) begin
      status_r <= status;
    end
  end

  assign out_status.valid        = valid_r;
  assign out_status.check_status = STATUS_W'(status_r);

endmodule
